### design/mcur_pkg.sv
// Shared types and constants for the multi-channel ultrasonic ranger.
// Used by multi_channel_ultrasonic_ranger_top; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mcur_pkg;

  // Sensor set: how many sensors are served and how many lines exist.
  localparam int SENSOR_CNT = 5;
  localparam int SENSOR_W   = (SENSOR_CNT > 1) ? $clog2(SENSOR_CNT) : 1;
  localparam int LINE_CNT   = 5;
  localparam int IDX_W      = 3;

  // Field widths.
  localparam int TICK_W = 16;
  localparam int DIST_W = 17;
  localparam int SHORT_W = 8;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_SEL_W = 3;

  // Register indexes within the configuration space.
  localparam logic [REG_SEL_W-1:0] REG_PRE_LOW   = 3'd0;
  localparam logic [REG_SEL_W-1:0] REG_TRIG_HIGH = 3'd1;
  localparam logic [REG_SEL_W-1:0] REG_RISE_TO   = 3'd2;
  localparam logic [REG_SEL_W-1:0] REG_ECHO_TO   = 3'd3;
  localparam logic [REG_SEL_W-1:0] REG_GAP       = 3'd4;

  // Register reset values.
  localparam logic [SHORT_W-1:0] PRE_LOW_RST   = 8'd4;
  localparam logic [SHORT_W-1:0] TRIG_HIGH_RST = 8'd20;
  localparam logic [TICK_W-1:0]  RISE_TO_RST   = 16'd10000;
  localparam logic [TICK_W-1:0]  ECHO_TO_RST   = 16'd15000;
  localparam logic [SHORT_W-1:0] GAP_RST       = 8'd20;

  // Distance reported on any timeout.
  localparam logic signed [DIST_W-1:0] DIST_TIMEOUT = -17'sd1;

  // Measurement phases, one-hot.
  typedef enum logic [4:0] {
    PH_PRE_LOW   = 5'b00001,
    PH_TRIG_HIGH = 5'b00010,
    PH_WAIT_RISE = 5'b00100,
    PH_ECHO_HIGH = 5'b01000,
    PH_GAP       = 5'b10000
  } phase_t;

endpackage : mcur_pkg

`default_nettype wire

### design/multi_channel_ultrasonic_ranger_top.sv
// Top level of the multi-channel ultrasonic ranger: tick register, phase logic,
// result register and configuration registers. Depends on mcur_pkg.
//
//   Channel  Ports                     Direction  Moves
//   input    in_valid/in_ready         in         one timer tick with echo levels
//   result   out_valid/out_ready       out        trigger lines and finished distance
//   config   psel/penable/pwrite/...   in         APB register writes and reads
//
// One item is taken every cycle while the result channel is not stalled; each item passes
// through the tick register, then the result register that holds the phase update.
// Reset (rst_n low, synchronous) puts the sequencer in the pre-low phase on
// sensor 0 and loads the register reset values.
// A stalled result holds the result register; the tick register still takes one
// more item, after which in_ready follows out_ready.
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_ultrasonic_ranger_top
  import mcur_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Input channel
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [LINE_CNT-1:0]      in_echo_levels,
  // Result channel
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [LINE_CNT-1:0]           out_trigger_lines,
  output logic                          out_sample_done,
  output logic [IDX_W-1:0]              out_sensor_index,
  output logic signed [DIST_W-1:0]      out_distance_ticks,
  // Configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ADDR_W-1:0]        paddr,
  input  wire logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready
);

  // Configuration registers.
  logic [SHORT_W-1:0] pre_low_r;
  logic [SHORT_W-1:0] trig_high_r;
  logic [TICK_W-1:0]  rise_to_r;
  logic [TICK_W-1:0]  echo_to_r;
  logic [SHORT_W-1:0] gap_r;

  logic                 cfg_wr;
  logic [REG_SEL_W-1:0] reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_low_r   <= PRE_LOW_RST;
      trig_high_r <= TRIG_HIGH_RST;
      rise_to_r   <= RISE_TO_RST;
      echo_to_r   <= ECHO_TO_RST;
      gap_r       <= GAP_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PRE_LOW:   pre_low_r   <= pwdata[SHORT_W-1:0];
        REG_TRIG_HIGH: trig_high_r <= pwdata[SHORT_W-1:0];
        REG_RISE_TO:   rise_to_r   <= pwdata[TICK_W-1:0];
        REG_ECHO_TO:   echo_to_r   <= pwdata[TICK_W-1:0];
        REG_GAP:       gap_r       <= pwdata[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_PRE_LOW:   prdata = DATA_W'(pre_low_r);
      REG_TRIG_HIGH: prdata = DATA_W'(trig_high_r);
      REG_RISE_TO:   prdata = DATA_W'(rise_to_r);
      REG_ECHO_TO:   prdata = DATA_W'(echo_to_r);
      REG_GAP:       prdata = DATA_W'(gap_r);
      default:       prdata = '0;
    endcase
  end

  // Pipeline flow control: the result register advances when empty or taken.
  logic               s1_valid_r;
  logic [LINE_CNT-1:0] s1_echo_r;
  logic               out_valid_r;
  logic               s2_load;
  logic               s1_load;

  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;
  assign s1_load  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_echo_r <= in_echo_levels;
    end
  end

  // Sequencer state.
  phase_t              phase_r, phase_nxt;
  logic [SENSOR_W-1:0] sensor_r, sensor_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;

  // Line masks of the current and the next sensor.
  logic [LINE_CNT-1:0] cur_mask;
  logic [LINE_CNT-1:0] nxt_mask;
  logic                echo;

  always_comb begin
    for (int i = 0; i < LINE_CNT; i++) begin
      cur_mask[i] = (32'(sensor_r) == i);
      nxt_mask[i] = (32'(sensor_nxt) == i);
    end
  end

  assign echo = |(s1_echo_r & cur_mask);

  // Phase logic for one tick; gap, pre-low and trigger may chain in one tick.
  logic                     go_pre;
  logic                     go_trig;
  logic [TICK_W-1:0]        pre_base;
  logic [TICK_W-1:0]        trig_base;
  logic [TICK_W:0]          tick_inc;
  logic [TICK_W:0]          trig_inc;
  logic [LINE_CNT-1:0]      trig_nxt;
  logic                     done_nxt;
  logic signed [DIST_W-1:0] dist_nxt;

  assign tick_inc = {1'b0, tick_r} + 17'd1;

  always_comb begin
    phase_nxt  = phase_r;
    sensor_nxt = sensor_r;
    tick_nxt   = tick_r;
    go_pre     = 1'b0;
    go_trig    = 1'b0;
    done_nxt   = 1'b0;
    dist_nxt   = '0;

    // Gap phase: idle, then step to the next sensor.
    if (phase_r == PH_GAP) begin
      if (tick_r >= TICK_W'(gap_r)) begin
        sensor_nxt = (32'(sensor_r) == SENSOR_CNT - 1) ? '0 : sensor_r + 1'b1;
        phase_nxt  = PH_PRE_LOW;
        tick_nxt   = '0;
        go_pre     = 1'b1;
      end else begin
        tick_nxt = tick_inc[TICK_W-1:0];
      end
    end

    // Pre-low phase, possibly entered on this tick.
    pre_base = go_pre ? '0 : tick_r;
    if (phase_r == PH_PRE_LOW || go_pre) begin
      if (pre_base >= TICK_W'(pre_low_r)) begin
        phase_nxt = PH_TRIG_HIGH;
        tick_nxt  = '0;
        go_trig   = 1'b1;
      end else begin
        tick_nxt = pre_base + 1'b1;
      end
    end

    // Trigger-high phase, possibly entered on this tick.
    trig_base = go_trig ? '0 : tick_r;
    trig_inc  = {1'b0, trig_base} + 17'd1;
    if (phase_r == PH_TRIG_HIGH || go_trig) begin
      if (trig_inc >= (TICK_W + 1)'(trig_high_r)) begin
        phase_nxt = PH_WAIT_RISE;
        tick_nxt  = '0;
      end else begin
        tick_nxt = trig_inc[TICK_W-1:0];
      end
    end

    // Wait for the echo to rise.
    if (phase_r == PH_WAIT_RISE) begin
      if (echo) begin
        phase_nxt = PH_ECHO_HIGH;
        tick_nxt  = '0;
      end else if (tick_inc >= {1'b0, rise_to_r}) begin
        done_nxt  = 1'b1;
        dist_nxt  = DIST_TIMEOUT;
        phase_nxt = PH_GAP;
        tick_nxt  = '0;
      end else begin
        tick_nxt = tick_inc[TICK_W-1:0];
      end
    end

    // Count the echo high time.
    if (phase_r == PH_ECHO_HIGH) begin
      if (!echo) begin
        done_nxt  = 1'b1;
        dist_nxt  = $signed({1'b0, tick_r});
        phase_nxt = PH_GAP;
        tick_nxt  = '0;
      end else if (tick_inc >= {1'b0, echo_to_r}) begin
        done_nxt  = 1'b1;
        dist_nxt  = DIST_TIMEOUT;
        phase_nxt = PH_GAP;
        tick_nxt  = '0;
      end else begin
        tick_nxt = tick_inc[TICK_W-1:0];
      end
    end
  end

  // The trigger is driven only in the trigger-high phase, on the sensor in service.
  assign trig_nxt = (phase_r == PH_TRIG_HIGH || go_trig) ? nxt_mask : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PRE_LOW;
      sensor_r <= '0;
      tick_r   <= '0;
    end else if (s2_load) begin
      phase_r  <= phase_nxt;
      sensor_r <= sensor_nxt;
      tick_r   <= tick_nxt;
    end
  end

  // Result register.
  logic [LINE_CNT-1:0]      trig_r;
  logic                     done_r;
  logic [IDX_W-1:0]         idx_r;
  logic signed [DIST_W-1:0] dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      trig_r <= trig_nxt;
      done_r <= done_nxt;
      idx_r  <= done_nxt ? IDX_W'(sensor_r) : '0;
      dist_r <= dist_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trigger_lines  = trig_r;
  assign out_sample_done    = done_r;
  assign out_sensor_index   = idx_r;
  assign out_distance_ticks = dist_r;

  // A tick that finishes nothing reports index and distance of zero.
  a_idle_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_sample_done) |-> (out_sensor_index == '0 && out_distance_ticks == '0))
    else $error("result without a finished measurement carries a distance");

  // At most one trigger line is driven.
  a_trig_onehot : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_trigger_lines))
    else $error("more than one trigger line driven");

  // A finished measurement never coincides with a trigger pulse.
  a_done_no_trig : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sample_done) |-> (out_trigger_lines == '0))
    else $error("trigger driven on a finishing tick");

  // A result held under stall keeps its value.
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_distance_ticks)
                                   && $stable(out_trigger_lines)))
    else $error("stalled result changed");

endmodule : multi_channel_ultrasonic_ranger_top

`default_nettype wire
